### hdl/sta_pkg.sv
// Shared constants for the strided tensor address generator.
package sta_pkg;
    localparam int REG_DIMS      = 4;
    localparam int EXT_W         = 16;
    localparam int STEP_W        = 24;
    localparam int OFF_W         = 32;
    localparam int IN_W          = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int DIV_BITS      = 4;
    localparam int DEF_MAX_DIMS  = 4;
    localparam int DEF_INDEX_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_0   = 3'd4;
endpackage

### hdl/sta_divmod.sv
// Pipelined restoring divider: quotient and remainder, DIV_BITS quotient bits per stage.
module sta_divmod #(
    parameter int IW = sta_pkg::DEF_INDEX_BITS,
    parameter int SW = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [IW-1:0]             i_num,
    input  logic [sta_pkg::EXT_W-1:0] i_den,
    input  logic [SW-1:0]             i_side,
    output logic                      o_valid,
    output logic [IW-1:0]             o_quo,
    output logic [sta_pkg::EXT_W-1:0] o_rem,
    output logic [SW-1:0]             o_side
);
    localparam int EW   = sta_pkg::EXT_W;
    localparam int DB   = sta_pkg::DIV_BITS;
    localparam int NSTG = (IW + DB - 1) / DB;

    logic          r_vld  [NSTG];
    logic [IW-1:0] r_num  [NSTG];
    logic [EW-1:0] r_rem  [NSTG];
    logic [SW-1:0] r_side [NSTG];
    logic [IW-1:0] n_num  [NSTG];
    logic [EW-1:0] n_rem  [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            logic          a_vld;
            logic [IW-1:0] a_num;
            logic [EW-1:0] a_rem;
            logic [SW-1:0] a_side;

            if (s == 0) begin : g_first
                assign a_vld  = i_valid;
                assign a_num  = i_num;
                assign a_rem  = '0;
                assign a_side = i_side;
            end else begin : g_next
                assign a_vld  = r_vld[s-1];
                assign a_num  = r_num[s-1];
                assign a_rem  = r_rem[s-1];
                assign a_side = r_side[s-1];
            end

            always_comb begin
                logic [IW-1:0] num;
                logic [EW-1:0] rem;
                logic [EW:0]   t;
                num = a_num;
                rem = a_rem;
                t   = '0;
                for (int j = 0; j < DB; j++) begin
                    if (s * DB + j < IW) begin
                        t   = {rem, num[IW-1]};
                        num = {num[IW-2:0], 1'b0};
                        if (t >= {1'b0, i_den}) begin
                            t      = t - {1'b0, i_den};
                            num[0] = 1'b1;
                        end
                        rem = t[EW-1:0];
                    end
                end
                n_num[s] = num;
                n_rem[s] = rem;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= a_vld;
                end
                if (i_en) begin
                    r_num[s]  <= n_num[s];
                    r_rem[s]  <= n_rem[s];
                    r_side[s] <= a_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NSTG-1];
    assign o_quo   = r_num[NSTG-1];
    assign o_rem   = r_rem[NSTG-1];
    assign o_side  = r_side[NSTG-1];
endmodule

### hdl/sta_mac.sv
// Digit times stride products, then the offset sum into the output register.
module sta_mac #(
    parameter int ND = sta_pkg::DEF_MAX_DIMS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [ND*sta_pkg::EXT_W-1:0] i_digits,
    input  logic [sta_pkg::STEP_W-1:0] i_step [sta_pkg::REG_DIMS],
    output logic                       o_valid,
    output logic [sta_pkg::OFF_W-1:0]  o_sum
);
    localparam int EW = sta_pkg::EXT_W;
    localparam int OW = sta_pkg::OFF_W;
    localparam int PW = sta_pkg::EXT_W + sta_pkg::STEP_W;

    logic          r_pvld;
    logic [OW-1:0] r_prod [ND];
    logic [PW-1:0] n_prod [ND];
    logic          r_svld;
    logic [OW-1:0] r_sum;
    logic [OW-1:0] n_sum;

    always_comb begin
        for (int d = 0; d < ND; d++) begin
            n_prod[d] = PW'(i_digits[d*EW +: EW]) * PW'(i_step[d]);
        end
        n_sum = '0;
        for (int d = 0; d < ND; d++) begin
            n_sum = n_sum + r_prod[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_svld <= 1'b0;
        end else if (i_en) begin
            r_pvld <= i_valid;
            r_svld <= r_pvld;
        end
        if (i_en) begin
            for (int d = 0; d < ND; d++) begin
                r_prod[d] <= n_prod[d][OW-1:0];
            end
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_svld;
    assign o_sum   = r_sum;
endmodule

### hdl/strided_tensor_address_gen.sv
// Top level: strided tensor address generator.
// Each item passes through every dimension's divider stages, then the product and sum registers.
// Throughput: one item per cycle unless stalled; each dimension runs a pipelined divider, 4 bits a stage.
// The whole pipeline stalls only while the output register holds an item not taken.
// Synchronous active-low reset clears valid bits; extents reset to 1, strides to 0.
module strided_tensor_address_gen #(
    parameter int MAX_DIMS   = sta_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = sta_pkg::DEF_INDEX_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sta_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sta_pkg::IN_W-1:0]       s_axis_tdata,  // [23:0] element_index
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sta_pkg::OFF_W-1:0]      m_axis_tdata   // [31:0] source_offset
);
    localparam int EW   = sta_pkg::EXT_W;
    localparam int SWD  = sta_pkg::STEP_W;
    localparam int RD   = sta_pkg::REG_DIMS;
    localparam int ND   = (MAX_DIMS < RD) ? MAX_DIMS : RD;
    localparam int IW   = INDEX_BITS;
    localparam int XW   = (IW > sta_pkg::IN_W) ? IW : sta_pkg::IN_W;
    localparam int SW   = ND * EW + 1;

    logic [EW-1:0]  r_ext  [RD];
    logic [SWD-1:0] r_step [RD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < RD; d++) begin
                r_ext[d]  <= EW'(1);
                r_step[d] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr < sta_pkg::CFG_STEP_0) begin
                r_ext[i_cfg_addr[1:0]] <= i_cfg_wdata[EW-1:0];
            end else begin
                r_step[i_cfg_addr[1:0]] <= i_cfg_wdata;
            end
        end
    end

    logic          w_en;
    logic          w_mvld;

    logic [XW-1:0] w_ext;
    assign w_ext = XW'(s_axis_tdata);

    logic          c_vld  [ND+1];
    logic [IW-1:0] c_num  [ND+1];
    logic [SW-1:0] c_side [ND+1];

    assign c_vld[0]  = s_axis_tvalid;
    assign c_num[0]  = w_ext[IW-1:0];
    assign c_side[0] = '0;

    genvar d;
    generate
        for (d = 0; d < ND; d++) begin : g_dim
            logic          o_vld;
            logic [IW-1:0] o_quo;
            logic [EW-1:0] o_rem;
            logic [SW-1:0] o_sd;
            logic          w_empty;

            sta_divmod #(.IW(IW), .SW(SW)) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (c_vld[d]),
                .i_num   (c_num[d]),
                .i_den   (r_ext[d]),
                .i_side  (c_side[d]),
                .o_valid (o_vld),
                .o_quo   (o_quo),
                .o_rem   (o_rem),
                .o_side  (o_sd)
            );

            assign w_empty  = o_sd[SW-1] | (r_ext[d] == '0);
            assign c_vld[d+1] = o_vld;
            assign c_num[d+1] = o_quo;
            always_comb begin
                c_side[d+1] = o_sd;
                c_side[d+1][SW-1] = w_empty;
                c_side[d+1][d*EW +: EW] = w_empty ? '0 : o_rem;
            end
        end
    endgenerate

    sta_mac #(.ND(ND)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (c_vld[ND]),
        .i_digits (c_side[ND][ND*EW-1:0]),
        .i_step   (r_step),
        .o_valid  (w_mvld),
        .o_sum    (m_axis_tdata)
    );

    assign w_en          = ~(w_mvld & ~m_axis_tready);
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = w_mvld;
endmodule
